>>> rtl/core/assert_macros.svh
// assertion macros shared by the allocator rtl
// expects aclk and aresetn in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMPL(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/pfla_pkg.sv
// shared constants, types and command/status structs of the allocator
// no dependencies
`default_nettype none
package pfla_pkg;
    localparam int MEM_LOG2     = 20;
    localparam int MIN_BLK_LOG2 = 5;
    localparam int NCLASS       = MEM_LOG2 - MIN_BLK_LOG2;
    localparam int IDX_W        = MEM_LOG2 - MIN_BLK_LOG2;
    localparam int NBLK         = 1 << IDX_W;
    localparam int CLS_W        = 4;
    localparam int CNT_W        = 21;
    localparam int ADDR_W       = 20;
    localparam int SIZE_W       = 31;
    localparam int HDR_W        = 7;
    localparam int SUM_W        = CNT_W + 1;
    localparam int LOG_W        = 5;
    localparam logic [HDR_W-1:0] HDR_RESET = 7'd32;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
    localparam logic [2:0] ST_OUT_OF_MEM = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR   = 3'd3;
    localparam logic [2:0] ST_NOT_IN_USE = 3'd4;

    typedef struct packed {
        logic             in_use;
        logic [CLS_W-1:0] cls;
        logic [CNT_W-1:0] req;
        logic [IDX_W-1:0] link;
    } ram_word_t;

    localparam int WORD_W = $bits(ram_word_t);

    typedef struct packed {
        logic       clr_wr;
        logic       latch_in;
        logic       calc_sum;
        logic       calc_need;
        logic       rd_head;
        logic       pop;
        logic       split;
        logic       alloc_wr;
        logic       free_rd;
        logic       free_wr;
        logic       fin;
        logic       set_status;
        logic [2:0] status;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic too_large;
        logic addr_null;
        logic addr_bad;
        logic no_fit;
        logic split_more;
        logic split_again;
        logic not_used;
        logic out_busy;
    } sts_t;
endpackage
`default_nettype wire

>>> rtl/core/pfla_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module pfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/pfla_ctrl.sv
// controller state machine of the allocator
// depends on pfla_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module pfla_ctrl
    import pfla_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_NEED  = 4'd3;
    localparam logic [3:0] S_SEL   = 4'd4;
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_SPLIT = 4'd6;
    localparam logic [3:0] S_AWR   = 4'd7;
    localparam logic [3:0] S_FREE  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CHK;
                end
            end
            S_CHK: begin
                if (!sts.is_free) begin
                    if (sts.too_large) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_TOO_LARGE;
                        state_next     = S_FIN;
                    end else begin
                        cmd.calc_sum = 1'b1;
                        state_next   = S_NEED;
                    end
                end else if (sts.addr_null) begin
                    state_next = S_FIN;
                end else if (sts.addr_bad) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_BAD_ADDR;
                    state_next     = S_FIN;
                end else begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FREE;
                end
            end
            S_NEED: begin
                cmd.calc_need = 1'b1;
                state_next    = S_SEL;
            end
            S_SEL: begin
                if (sts.no_fit) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OUT_OF_MEM;
                    state_next     = S_FIN;
                end else begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_POP;
                end
            end
            S_POP: begin
                cmd.pop    = 1'b1;
                state_next = sts.split_more ? S_SPLIT : S_AWR;
            end
            S_SPLIT: begin
                cmd.split = 1'b1;
                if (!sts.split_again) state_next = S_AWR;
            end
            S_AWR: begin
                cmd.alloc_wr = 1'b1;
                state_next   = S_FIN;
            end
            S_FREE: begin
                if (sts.not_used) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_IN_USE;
                end else begin
                    cmd.free_wr = 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!sts.out_busy) begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    `AST_IMPL(a_split_has_work, state_reg == S_SPLIT, sts.split_more)
    `AST_NEXT(a_accept_to_check, s_tvalid && s_tready, state_reg == S_CHK)
    `AST_IMPL(a_no_accept_in_clear, state_reg == S_CLEAR, !s_tready)
endmodule
`default_nettype wire

>>> rtl/core/pfla_dp.sv
// datapath: list heads, bitmap, counters, block ram and result register
// depends on pfla_pkg and pfla_ram
`default_nettype none
module pfla_dp
    import pfla_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic                cfg_valid,
    input  wire logic [HDR_W-1:0]    cfg_data,
    input  wire logic                in_type,
    input  wire logic [SIZE_W-1:0]   in_size,
    input  wire logic [ADDR_W-1:0]   in_addr,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [2:0]               out_status,
    output logic [ADDR_W-1:0]        out_gaddr,
    output logic [CNT_W-1:0]         out_gbytes,
    output logic [CNT_W-1:0]         out_usage,
    output logic [CNT_W-1:0]         out_waste,
    output logic [CNT_W-1:0]         out_peak
);
    logic [HDR_W-1:0]  hdr_reg;
    logic              type_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SUM_W-1:0]  sm1_reg;
    logic [CLS_W-1:0]  need_reg, cand_reg;
    logic              no_fit_reg;
    logic [IDX_W-1:0]  x_reg;
    logic [IDX_W-1:0]  clr_reg;
    logic [2:0]        status_reg;
    logic [ADDR_W-1:0] gaddr_reg;
    logic [CNT_W-1:0]  gbytes_reg;
    logic              alloc_ok_reg;
    logic [CNT_W-1:0]  usage_reg, waste_reg, peak_reg;
    logic [NCLASS-1:0] map_reg;
    logic [IDX_W-1:0]  heads_reg [NCLASS];

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    ram_word_t         ram_wdata, ram_rdata;
    logic [WORD_W-1:0] ram_rbits;

    logic [IDX_W-1:0]  idx;
    logic [SUM_W-1:0]  sum;
    logic [LOG_W-1:0]  wlog, need5;
    logic [NCLASS-1:0] avail;
    logic [CLS_W-1:0]  cand_sel;
    logic              cand_found;
    logic [CLS_W-1:0]  split_cls;
    logic [IDX_W-1:0]  half;
    logic [CLS_W-1:0]  free_cls;
    logic [CNT_W-1:0]  alloc_bsz, free_bsz;
    logic [CNT_W-1:0]  peak_new;

    assign idx = addr_reg[ADDR_W-1 -: IDX_W];
    assign ram_rdata = ram_word_t'(ram_rbits);

    // ceil log2 of size plus header, taken from the registered value size + header - 1
    assign sum = {1'b0, size_reg[CNT_W-1:0]} + SUM_W'(hdr_reg);
    always_comb begin
        wlog = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (sm1_reg[i]) wlog = LOG_W'(i + 1);
        end
        need5 = (wlog <= LOG_W'(MIN_BLK_LOG2)) ? '0 : wlog - LOG_W'(MIN_BLK_LOG2);
    end

    // smallest non-empty class at or above the needed one
    always_comb begin
        cand_sel   = '0;
        cand_found = 1'b0;
        for (int k = 0; k < NCLASS; k++) begin
            avail[k] = map_reg[k] && (LOG_W'(k) >= need5);
        end
        for (int k = NCLASS - 1; k >= 0; k--) begin
            if (avail[k]) begin
                cand_sel   = CLS_W'(k);
                cand_found = 1'b1;
            end
        end
    end

    assign split_cls = cand_reg - CLS_W'(1);
    assign half      = x_reg + (IDX_W'(1) << split_cls);
    assign alloc_bsz = CNT_W'(1) << (LOG_W'(need_reg) + LOG_W'(MIN_BLK_LOG2));
    assign free_cls  = (ram_rdata.cls >= CLS_W'(NCLASS)) ? CLS_W'(NCLASS - 1)
                                                          : ram_rdata.cls;
    assign free_bsz  = CNT_W'(1) << (LOG_W'(free_cls) + LOG_W'(MIN_BLK_LOG2));
    assign peak_new  = (alloc_ok_reg && usage_reg > peak_reg) ? usage_reg : peak_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        priority if (cmd.clr_wr) begin
            ram_we = 1'b1;
        end else if (cmd.split) begin
            ram_we         = 1'b1;
            ram_waddr      = half;
            ram_wdata.cls  = split_cls;
            ram_wdata.link = map_reg[split_cls] ? heads_reg[split_cls] : '0;
        end else if (cmd.alloc_wr) begin
            ram_we           = 1'b1;
            ram_waddr        = x_reg;
            ram_wdata.in_use = 1'b1;
            ram_wdata.cls    = need_reg;
            ram_wdata.req    = size_reg[CNT_W-1:0];
        end else if (cmd.free_wr) begin
            ram_we         = 1'b1;
            ram_waddr      = idx;
            ram_wdata.cls  = free_cls;
            ram_wdata.req  = ram_rdata.req;
            ram_wdata.link = map_reg[free_cls] ? heads_reg[free_cls] : '0;
        end
    end

    assign ram_re    = cmd.rd_head || cmd.free_rd;
    assign ram_raddr = cmd.rd_head ? heads_reg[cand_reg] : idx;

    pfla_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NBLK)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (WORD_W'(ram_wdata)),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rbits)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg   <= HDR_RESET;
            clr_reg   <= '0;
            usage_reg <= '0;
            waste_reg <= '0;
            peak_reg  <= '0;
            map_reg   <= '1;
            m_tvalid  <= 1'b0;
            for (int k = 0; k < NCLASS; k++) begin
                heads_reg[k] <= IDX_W'(1) << k;
            end
        end else begin
            if (cfg_valid) hdr_reg <= cfg_data;
            if (cmd.clr_wr) clr_reg <= clr_reg + IDX_W'(1);
            if (cmd.pop) begin
                heads_reg[cand_reg] <= ram_rdata.link;
                if (ram_rdata.link == '0) map_reg[cand_reg] <= 1'b0;
            end
            if (cmd.split) begin
                heads_reg[split_cls] <= half;
                map_reg[split_cls]   <= 1'b1;
            end
            if (cmd.alloc_wr) begin
                usage_reg <= usage_reg + alloc_bsz;
                waste_reg <= waste_reg + (alloc_bsz - size_reg[CNT_W-1:0]);
            end
            if (cmd.free_wr) begin
                usage_reg            <= usage_reg - free_bsz;
                waste_reg            <= waste_reg - (free_bsz - ram_rdata.req);
                heads_reg[free_cls] <= idx;
                map_reg[free_cls]   <= 1'b1;
            end
            if (cmd.fin) begin
                peak_reg <= peak_new;
                m_tvalid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // per-item payload
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            type_reg     <= in_type;
            size_reg     <= in_size;
            addr_reg     <= in_addr;
            status_reg   <= ST_OK;
            gaddr_reg    <= '0;
            gbytes_reg   <= '0;
            alloc_ok_reg <= 1'b0;
        end
        if (cmd.set_status) status_reg <= cmd.status;
        if (cmd.calc_sum) sm1_reg <= (sum == '0) ? '0 : sum - SUM_W'(1);
        if (cmd.calc_need) begin
            need_reg   <= need5[CLS_W-1:0];
            cand_reg   <= cand_sel;
            no_fit_reg <= !cand_found;
        end
        if (cmd.rd_head) x_reg <= heads_reg[cand_reg];
        if (cmd.split) cand_reg <= split_cls;
        if (cmd.alloc_wr) begin
            gaddr_reg    <= {x_reg, MIN_BLK_LOG2'(0)};
            gbytes_reg   <= alloc_bsz;
            alloc_ok_reg <= 1'b1;
        end
        if (cmd.fin) begin
            out_status <= status_reg;
            out_gaddr  <= gaddr_reg;
            out_gbytes <= gbytes_reg;
            out_usage  <= usage_reg;
            out_waste  <= waste_reg;
            out_peak   <= peak_new;
        end
    end

    always_comb begin
        sts.clr_last    = (clr_reg == IDX_W'(NBLK - 1));
        sts.is_free     = type_reg;
        sts.too_large   = (size_reg > SIZE_W'(1 << MEM_LOG2));
        sts.addr_null   = (addr_reg == '0);
        sts.addr_bad    = (addr_reg[MIN_BLK_LOG2-1:0] != '0);
        sts.no_fit      = no_fit_reg;
        sts.split_more  = (cand_reg > need_reg);
        sts.split_again = (split_cls > need_reg);
        sts.not_used    = !ram_rdata.in_use;
        sts.out_busy    = m_tvalid && !m_tready;
    end
endmodule
`default_nettype wire

>>> rtl/core/pow2_free_list_allocator_unit.sv
// Power-of-two free-list allocator over a 1 MiB region, 15 classes from 32 bytes.
// After reset the unit runs a clearing pass over the 32768-entry block memory,
// during which no request is taken (header writes still are). A granted allocate
// finds the class, pops a block, splits it (a link-memory write per split, up to 14,
// which sets the allocate time) and writes the header; out of memory ends it after
// the class search; a free reads the block and writes it back if in use; too large,
// bad address and null frees end after the check. One request is worked at a time;
// the next may be taken while the previous result waits on the master side.
// depends on pfla_pkg, pfla_ctrl, pfla_dp
`default_nettype none
module pow2_free_list_allocator_unit
    import pfla_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [6:0]   cfg_data,    // header_bytes
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [55:0]  s_tdata,     // req_size[30:0], block_address[50:31], zero pad
    input  wire logic         s_tuser,     // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,     // granted_address, granted_bytes, usage, waste, peak
    output logic [2:0]        m_tuser      // status
);
    cmd_t              cmd;
    sts_t              sts;
    logic [2:0]        out_status;
    logic [ADDR_W-1:0] out_gaddr;
    logic [CNT_W-1:0]  out_gbytes, out_usage, out_waste, out_peak;

    assign cfg_ready = 1'b1;

    pfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfla_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_type    (s_tuser),
        .in_size    (s_tdata[SIZE_W-1:0]),
        .in_addr    (s_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (out_status),
        .out_gaddr  (out_gaddr),
        .out_gbytes (out_gbytes),
        .out_usage  (out_usage),
        .out_waste  (out_waste),
        .out_peak   (out_peak)
    );

    assign m_tdata = {out_peak, out_waste, out_usage, out_gbytes, out_gaddr};
    assign m_tuser = out_status;
endmodule
`default_nettype wire
